FILE: design/fls_pkg.sv
// ----------------------------------------------------------------------------
// fls_pkg - float literal scanner shared definitions
// Word types, scan state, character codes and the word letter tables.
// ----------------------------------------------------------------------------
`default_nettype none

package fls_pkg;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_SIGNED,
        PH_WORD,
        PH_INT,
        PH_FRAC,
        PH_EXP_START,
        PH_EXP_SIGN,
        PH_EXP_DIGITS,
        PH_TRAIL,
        PH_FAIL
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_INF,
        KIND_NAN
    } word_kind_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_end;
    } in_word_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] clean_char;
        logic       done_res;
        logic       accepted;
    } out_word_t;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] word_position;
        word_kind_t word_kind;
        logic       mantissa_seen;
        logic       run_has_digit;
        logic       underscore_pending;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        phase:              PH_LEAD,
        word_position:      3'd0,
        word_kind:          KIND_NONE,
        mantissa_seen:      1'b0,
        run_has_digit:      1'b0,
        underscore_pending: 1'b0
    };

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_E    = 8'h45;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_E    = 8'h65;
    localparam logic [7:0] CH_LOWER_F    = 8'h66;
    localparam logic [7:0] CH_LOWER_I    = 8'h69;
    localparam logic [7:0] CH_LOWER_N    = 8'h6E;
    localparam logic [7:0] CH_LOWER_T    = 8'h74;
    localparam logic [7:0] CH_LOWER_Y    = 8'h79;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z))
            to_lower = c + CASE_OFFSET;
        else
            to_lower = c;
    endfunction

    function automatic logic [7:0] inf_letter(input logic [2:0] pos);
        case (pos)
            3'd0:    inf_letter = CH_LOWER_I;
            3'd1:    inf_letter = CH_LOWER_N;
            3'd2:    inf_letter = CH_LOWER_F;
            3'd3:    inf_letter = CH_LOWER_I;
            3'd4:    inf_letter = CH_LOWER_N;
            3'd5:    inf_letter = CH_LOWER_I;
            3'd6:    inf_letter = CH_LOWER_T;
            default: inf_letter = CH_LOWER_Y;
        endcase
    endfunction

    function automatic logic [7:0] nan_letter(input logic [1:0] pos);
        case (pos)
            2'd0:    nan_letter = CH_LOWER_N;
            2'd1:    nan_letter = CH_LOWER_A;
            2'd2:    nan_letter = CH_LOWER_N;
            default: nan_letter = CH_NUL;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: design/fls_stream_if.sv
// ----------------------------------------------------------------------------
// fls_stream_if - valid/ready stream channel
// Carries one word per handshake; payload type set per instance.
// ----------------------------------------------------------------------------
`default_nettype none

interface fls_stream_if #(
    parameter type payload_t = logic [7:0]
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

FILE: design/fls_step.sv
// ----------------------------------------------------------------------------
// fls_step - scanner transition logic
// Computes next scan state and the result word for one input word.
// ----------------------------------------------------------------------------
`default_nettype none

module fls_step (
    input  var fls_pkg::scan_state_t state_cur,
    input  var fls_pkg::in_word_t    word_in,
    output fls_pkg::scan_state_t     state_next,
    output fls_pkg::out_word_t       word_out
);

    always_comb
    begin : step_blk
        fls_pkg::scan_state_t st;
        logic [7:0] c;
        logic [7:0] low;
        logic [7:0] expect_ch;
        logic [3:0] pos_inc;
        logic       cont;
        logic       ev;
        logic [7:0] ec;
        logic       acc;

        st        = state_cur;
        c         = word_in.char_in;
        low       = fls_pkg::to_lower(c);
        expect_ch = fls_pkg::CH_NUL;
        pos_inc   = 4'd0;
        cont      = 1'b1;
        ev        = 1'b0;
        ec        = fls_pkg::CH_NUL;
        acc       = 1'b0;

        if (word_in.is_end)
        begin
            case (state_cur.phase)
                fls_pkg::PH_WORD:
                    acc = (state_cur.word_kind == fls_pkg::KIND_INF) &&
                          (state_cur.word_position == 3'd3);
                fls_pkg::PH_INT, fls_pkg::PH_FRAC:
                    acc = state_cur.mantissa_seen && !state_cur.underscore_pending;
                fls_pkg::PH_EXP_DIGITS:
                    acc = state_cur.run_has_digit && !state_cur.underscore_pending;
                fls_pkg::PH_TRAIL:
                    acc = 1'b1;
                default:
                    acc = 1'b0;
            endcase
            st = fls_pkg::SCAN_RESET;
        end
        else if (state_cur.phase != fls_pkg::PH_FAIL)
        begin
            if (st.phase == fls_pkg::PH_LEAD)
            begin
                if (fls_pkg::is_space(c))
                    cont = 1'b0;
                else
                begin
                    st.phase = fls_pkg::PH_SIGNED;
                    if ((c == fls_pkg::CH_PLUS) || (c == fls_pkg::CH_MINUS))
                    begin
                        ev   = 1'b1;
                        ec   = c;
                        cont = 1'b0;
                    end
                end
            end

            if (cont && (st.phase == fls_pkg::PH_SIGNED))
            begin
                if ((low == fls_pkg::CH_LOWER_I) || (low == fls_pkg::CH_LOWER_N))
                begin
                    st.word_kind     = (low == fls_pkg::CH_LOWER_I) ?
                                       fls_pkg::KIND_INF : fls_pkg::KIND_NAN;
                    st.word_position = 3'd1;
                    st.phase         = fls_pkg::PH_WORD;
                    ev               = 1'b1;
                    ec               = low;
                    cont             = 1'b0;
                end
                else
                begin
                    st.phase         = fls_pkg::PH_INT;
                    st.run_has_digit = 1'b0;
                end
            end

            if (cont)
            begin
                case (st.phase)
                    fls_pkg::PH_WORD:
                    begin
                        if ((st.word_kind == fls_pkg::KIND_INF) &&
                            (st.word_position == 3'd3) && fls_pkg::is_space(c))
                            st.phase = fls_pkg::PH_TRAIL;
                        else
                        begin
                            expect_ch = (st.word_kind == fls_pkg::KIND_INF) ?
                                        fls_pkg::inf_letter(st.word_position) :
                                        fls_pkg::nan_letter(st.word_position[1:0]);
                            if ((low != expect_ch) || (expect_ch == fls_pkg::CH_NUL))
                                st.phase = fls_pkg::PH_FAIL;
                            else
                            begin
                                if (st.word_position < 3'd3)
                                begin
                                    ev = 1'b1;
                                    ec = expect_ch;
                                end
                                pos_inc = {1'b0, st.word_position} + 4'd1;
                                if (((st.word_kind == fls_pkg::KIND_NAN) &&
                                     (pos_inc >= 4'd3)) || (pos_inc >= 4'd8))
                                begin
                                    st.phase         = fls_pkg::PH_TRAIL;
                                    st.word_position = 3'd0;
                                end
                                else
                                    st.word_position = pos_inc[2:0];
                            end
                        end
                    end
                    fls_pkg::PH_INT, fls_pkg::PH_FRAC:
                    begin
                        if (fls_pkg::is_digit(c))
                        begin
                            st.run_has_digit      = 1'b1;
                            st.underscore_pending = 1'b0;
                            st.mantissa_seen      = 1'b1;
                            ev                    = 1'b1;
                            ec                    = c;
                        end
                        else if (st.underscore_pending)
                            st.phase = fls_pkg::PH_FAIL;
                        else if (c == fls_pkg::CH_UNDERSCORE)
                        begin
                            if (!st.run_has_digit)
                                st.phase = fls_pkg::PH_FAIL;
                            else
                                st.underscore_pending = 1'b1;
                        end
                        else if ((c == fls_pkg::CH_DOT) && (st.phase == fls_pkg::PH_INT))
                        begin
                            ev               = 1'b1;
                            ec               = c;
                            st.phase         = fls_pkg::PH_FRAC;
                            st.run_has_digit = 1'b0;
                        end
                        else if (((c == fls_pkg::CH_LOWER_E) || (c == fls_pkg::CH_UPPER_E)) &&
                                 st.mantissa_seen)
                        begin
                            ev               = 1'b1;
                            ec               = fls_pkg::CH_LOWER_E;
                            st.phase         = fls_pkg::PH_EXP_START;
                            st.run_has_digit = 1'b0;
                        end
                        else if (fls_pkg::is_space(c) && st.mantissa_seen)
                            st.phase = fls_pkg::PH_TRAIL;
                        else
                            st.phase = fls_pkg::PH_FAIL;
                    end
                    fls_pkg::PH_EXP_START, fls_pkg::PH_EXP_SIGN:
                    begin
                        if ((st.phase == fls_pkg::PH_EXP_START) &&
                            ((c == fls_pkg::CH_PLUS) || (c == fls_pkg::CH_MINUS)))
                        begin
                            ev       = 1'b1;
                            ec       = c;
                            st.phase = fls_pkg::PH_EXP_SIGN;
                        end
                        else if (fls_pkg::is_digit(c))
                        begin
                            ev               = 1'b1;
                            ec               = c;
                            st.run_has_digit = 1'b1;
                            st.phase         = fls_pkg::PH_EXP_DIGITS;
                        end
                        else
                            st.phase = fls_pkg::PH_FAIL;
                    end
                    fls_pkg::PH_EXP_DIGITS:
                    begin
                        if (fls_pkg::is_digit(c))
                        begin
                            st.run_has_digit      = 1'b1;
                            st.underscore_pending = 1'b0;
                            ev                    = 1'b1;
                            ec                    = c;
                        end
                        else if (st.underscore_pending)
                            st.phase = fls_pkg::PH_FAIL;
                        else if (c == fls_pkg::CH_UNDERSCORE)
                        begin
                            if (!st.run_has_digit)
                                st.phase = fls_pkg::PH_FAIL;
                            else
                                st.underscore_pending = 1'b1;
                        end
                        else if (fls_pkg::is_space(c))
                            st.phase = fls_pkg::PH_TRAIL;
                        else
                            st.phase = fls_pkg::PH_FAIL;
                    end
                    fls_pkg::PH_TRAIL:
                    begin
                        if (!fls_pkg::is_space(c))
                            st.phase = fls_pkg::PH_FAIL;
                    end
                    default:
                        st.phase = fls_pkg::PH_FAIL;
                endcase
            end

            if (st.phase == fls_pkg::PH_FAIL)
            begin
                ev = 1'b0;
                ec = fls_pkg::CH_NUL;
            end
        end

        state_next          = st;
        word_out.char_valid = ev;
        word_out.clean_char = ev ? ec : fls_pkg::CH_NUL;
        word_out.done_res   = word_in.is_end;
        word_out.accepted   = acc;
    end

endmodule

`default_nettype wire

FILE: design/float_literal_scanner.sv
// ----------------------------------------------------------------------------
// float_literal_scanner - streaming float literal checker
//
//   channel  dir  word        fields
//   in_ch    in   in_word_t   char_in, is_end
//   out_ch   out  out_word_t  char_valid, clean_char, done_res, accepted
//
// One word per cycle while the result is not stalled; each word gives exactly one result word.
// Path: input register, then scan logic into result register.
// Scan state updates as a word moves from the input to the result register.
// A stalled result holds both registers; in_ch.ready stays high while the
// input register is empty or moving. Reset returns the scan to leading space.
// ----------------------------------------------------------------------------
`default_nettype none

module float_literal_scanner (
    input  wire           clk,
    input  wire           rst_n,
    fls_stream_if.sink    in_ch,
    fls_stream_if.source  out_ch
);

    logic                 in_valid_reg;
    fls_pkg::in_word_t    in_word_reg;
    fls_pkg::scan_state_t state_reg;
    fls_pkg::scan_state_t state_next;
    logic                 out_valid_reg;
    fls_pkg::out_word_t   out_word_reg;
    fls_pkg::out_word_t   out_word_next;
    logic                 out_free;
    logic                 advance;

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign advance     = in_valid_reg && out_free;
    assign in_ch.ready = !in_valid_reg || out_free;

    fls_step u_step (
        .state_cur  (state_reg),
        .word_in    (in_word_reg),
        .state_next (state_next),
        .word_out   (out_word_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= fls_pkg::SCAN_RESET;
        end
        else
        begin
            if (in_ch.ready)
                in_valid_reg <= in_ch.valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
            in_word_reg <= in_ch.data;
        if (advance)
            out_word_reg <= out_word_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_word_reg;

endmodule

`default_nettype wire

FILE: design/fls_checker.sv
// ----------------------------------------------------------------------------
// fls_checker - result channel checks for the float literal scanner
// Watches the result port only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module fls_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                out_valid,
    input wire                out_ready,
    input var fls_pkg::out_word_t out_data
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    a_done_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> !out_data.char_valid)
        else $error("end result carries a character");

    a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.done_res |-> !out_data.accepted)
        else $error("accepted set without done");

    a_clean_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.char_valid |-> out_data.clean_char == 8'h00)
        else $error("clean_char nonzero without char_valid");

endmodule

bind float_literal_scanner fls_checker u_fls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

`default_nettype wire
